/* rtl/crs_pkg.sv */
// crs_pkg: shared types and constants of the connection retry scheduler.
// Used by crs_cell and connection_retry_scheduler_unit; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package crs_pkg;

  localparam int SLOTS_DEF     = 16;
  localparam int TIME_BITS_DEF = 32;
  localparam int CNT_W         = 8;
  localparam int INTERVAL_W    = 16;
  localparam int SCOUNT_W      = 5;
  localparam int SLOT_W        = 4;
  localparam int OUT_TIME_W    = 32;
  localparam int WIDE_W        = 64;

  localparam logic [INTERVAL_W-1:0] DEFAULT_INTERVAL = 16'd5;

  localparam logic REG_RETRY_INTERVAL = 1'b0;
  localparam logic REG_SLOT_COUNT     = 1'b1;

  localparam logic ACT_SERVICE   = 1'b0;
  localparam logic ACT_MARK_DOWN = 1'b1;

  localparam logic [1:0] RES_PENDING = 2'd0;
  localparam logic [1:0] RES_DONE    = 2'd1;
  localparam logic [1:0] RES_FAILED  = 2'd2;
  // spare outcome code, handled as failed
  localparam logic [1:0] RES_SPARE   = 2'd3;

  typedef enum logic [1:0] {
    MODE_DOWN       = 2'd0,
    MODE_CONNECTING = 2'd1,
    MODE_CONNECTED  = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    EV_NONE         = 3'd0,
    EV_STARTED      = 3'd1,
    EV_START_FAILED = 3'd2,
    EV_CONNECTED    = 3'd3,
    EV_CONN_FAILED  = 3'd4,
    EV_MARKED_DOWN  = 3'd5,
    EV_BAD_SLOT     = 3'd6
  } event_t;

  typedef struct packed {
    logic       action;
    logic [1:0] open_result;
    logic       start_ok;
    logic       iv_zero;
  } cmd_t;

endpackage

`default_nettype wire

/* rtl/connection_retry_scheduler_unit.sv */
// connection_retry_scheduler_unit: top level; config registers, row of
// crs_cell slots, scan counter and result registers. Depends on crs_pkg, crs_cell.
//
//  port group   direction  transfer
//  command      in         start high while busy low
//  result       out        done high for one cycle, cannot be held off
//  config       in         wr_en high, register wr_index takes wr_data
//
// The addressed slot updates at the accepting edge; the earliest deadline
// then ripples through the cell row, one cell per cycle, and done rises
// once it has left the last cell; the result transfers at the next
// edge, where the next command may already be taken. The receiver cannot
// stall; a command waits only on busy.
// Synchronous reset puts every slot down, due at time 0.
`timescale 1ns / 1ps
`default_nettype none

module connection_retry_scheduler_unit #(
  parameter int SLOTS     = crs_pkg::SLOTS_DEF,
  parameter int TIME_BITS = crs_pkg::TIME_BITS_DEF
) (
  input  wire                              clk,
  input  wire                              rst,
  input  wire                              start,
  output logic                             busy,
  input  wire                              action,
  input  wire  [crs_pkg::SLOT_W-1:0]       slot,
  input  wire  [crs_pkg::OUT_TIME_W-1:0]   now,
  input  wire  [1:0]                       open_result,
  input  wire                              start_ok,
  output logic                             done,
  output logic [1:0]                       slot_mode,
  output logic [2:0]                       event_code,
  output logic [crs_pkg::OUT_TIME_W-1:0]   slot_deadline,
  output logic                             slot_never,
  output logic [crs_pkg::OUT_TIME_W-1:0]   next_deadline,
  output logic                             next_valid,
  input  wire                              wr_en,
  input  wire                              wr_index,
  input  wire  [crs_pkg::INTERVAL_W-1:0]   wr_data
);

  localparam int CW = $clog2(SLOTS + 1);

  logic [crs_pkg::INTERVAL_W-1:0] retry_interval;
  logic [crs_pkg::SCOUNT_W-1:0]   slot_count;
  logic [crs_pkg::CNT_W-1:0]      n_eff;
  logic [crs_pkg::INTERVAL_W-1:0] iv16;
  logic [crs_pkg::WIDE_W-1:0]     iv_wide;
  logic [crs_pkg::WIDE_W-1:0]     now_wide;
  logic [TIME_BITS-1:0]           now_m;
  logic [TIME_BITS-1:0]           iv_m;
  crs_pkg::cmd_t                  cmd;
  logic                           accept;
  logic                           bad;
  logic [CW-1:0]                  cnt;
  logic [crs_pkg::SLOT_W-1:0]     slot_q;
  crs_pkg::event_t                code_q;
  crs_pkg::event_t                ev_sel;

  logic [SLOTS-1:0]                 sel;
  logic [SLOTS-1:0]                 active;
  logic [SLOTS-1:0]                 tok_found;
  logic [SLOTS-1:0][TIME_BITS-1:0]  tok_best;
  crs_pkg::event_t [SLOTS-1:0]      ev;
  crs_pkg::mode_t  [SLOTS-1:0]      mode;
  logic [SLOTS-1:0][TIME_BITS-1:0]  deadline;
  logic [SLOTS-1:0]                 never;

  logic [1:0]                    rd_mode;
  logic [TIME_BITS-1:0]          rd_deadline;
  logic                          rd_never;
  logic [crs_pkg::WIDE_W-1:0]    rd_dl_wide;
  logic [crs_pkg::WIDE_W-1:0]    best_wide;

  always_ff @(posedge clk) begin
    if (rst) begin
      retry_interval <= '0;
      slot_count     <= crs_pkg::SCOUNT_W'(1);
    end else if (wr_en) begin
      unique case (wr_index)
        crs_pkg::REG_RETRY_INTERVAL: retry_interval <= wr_data;
        crs_pkg::REG_SLOT_COUNT:     slot_count     <= wr_data[crs_pkg::SCOUNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign n_eff = ({3'b0, slot_count} > crs_pkg::CNT_W'(SLOTS)) ?
                 crs_pkg::CNT_W'(SLOTS) : {3'b0, slot_count};

  assign iv16 = (retry_interval != '0) ? retry_interval :
                (slot_count > crs_pkg::SCOUNT_W'(1)) ? crs_pkg::DEFAULT_INTERVAL : '0;

  assign iv_wide  = {48'b0, iv16};
  assign iv_m     = iv_wide[TIME_BITS-1:0];
  assign now_wide = {32'b0, now};
  assign now_m    = now_wide[TIME_BITS-1:0];

  assign cmd.action      = action;
  assign cmd.open_result = open_result;
  assign cmd.start_ok    = start_ok;
  assign cmd.iv_zero     = (iv16 == '0);

  assign accept = start && !busy;
  assign bad    = {4'b0, slot} >= n_eff;

  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    assign active[i] = crs_pkg::CNT_W'(i) < n_eff;
    assign sel[i]    = accept && !bad && ({4'b0, slot} == crs_pkg::CNT_W'(i));

    if (i == 0) begin : g_head
      crs_cell #(.TIME_BITS(TIME_BITS)) u_cell (
        .clk          (clk),
        .rst          (rst),
        .sel          (sel[i]),
        .active       (active[i]),
        .cmd          (cmd),
        .now          (now_m),
        .interval     (iv_m),
        .tok_found_in (1'b0),
        .tok_best_in  ('0),
        .tok_found    (tok_found[i]),
        .tok_best     (tok_best[i]),
        .ev           (ev[i]),
        .mode         (mode[i]),
        .deadline     (deadline[i]),
        .never        (never[i])
      );
    end else begin : g_link
      crs_cell #(.TIME_BITS(TIME_BITS)) u_cell (
        .clk          (clk),
        .rst          (rst),
        .sel          (sel[i]),
        .active       (active[i]),
        .cmd          (cmd),
        .now          (now_m),
        .interval     (iv_m),
        .tok_found_in (tok_found[i-1]),
        .tok_best_in  (tok_best[i-1]),
        .tok_found    (tok_found[i]),
        .tok_best     (tok_best[i]),
        .ev           (ev[i]),
        .mode         (mode[i]),
        .deadline     (deadline[i]),
        .never        (never[i])
      );
    end
  end

  always_comb begin
    ev_sel      = crs_pkg::EV_NONE;
    rd_mode     = '0;
    rd_deadline = '0;
    rd_never    = 1'b0;
    for (int i = 0; i < SLOTS; i++) begin
      if ({4'b0, slot} == crs_pkg::CNT_W'(i)) begin
        ev_sel = ev[i];
      end
      if ({4'b0, slot_q} == crs_pkg::CNT_W'(i)) begin
        rd_mode     = mode[i];
        rd_deadline = deadline[i];
        rd_never    = never[i];
      end
    end
  end

  assign rd_dl_wide = crs_pkg::WIDE_W'(rd_deadline);
  assign best_wide  = crs_pkg::WIDE_W'(tok_best[SLOTS-1]);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CW'(SLOTS));
      if (accept) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        if (cnt == CW'(SLOTS)) begin
          busy <= 1'b0;
        end else begin
          cnt <= cnt + CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      slot_q <= slot;
      code_q <= bad ? crs_pkg::EV_BAD_SLOT : ev_sel;
    end
    if (busy && cnt == CW'(SLOTS)) begin
      event_code <= code_q;
      if (code_q == crs_pkg::EV_BAD_SLOT) begin
        slot_mode     <= '0;
        slot_deadline <= '0;
        slot_never    <= 1'b0;
      end else begin
        slot_mode     <= rd_mode;
        slot_deadline <= rd_dl_wide[crs_pkg::OUT_TIME_W-1:0];
        slot_never    <= rd_never;
      end
      next_valid    <= tok_found[SLOTS-1];
      next_deadline <= tok_found[SLOTS-1] ? best_wide[crs_pkg::OUT_TIME_W-1:0] : '0;
    end
  end

endmodule

`default_nettype wire

/* rtl/crs_cell.sv */
// crs_cell: one channel slot (mode, deadline, never-retry mark) and one
// link of the registered minimum chain. Depends on crs_pkg.
`timescale 1ns / 1ps
`default_nettype none

module crs_cell #(
  parameter int TIME_BITS = crs_pkg::TIME_BITS_DEF
) (
  input  wire                      clk,
  input  wire                      rst,
  input  wire                      sel,
  input  wire                      active,
  input  crs_pkg::cmd_t            cmd,
  input  wire  [TIME_BITS-1:0]     now,
  input  wire  [TIME_BITS-1:0]     interval,
  input  wire                      tok_found_in,
  input  wire  [TIME_BITS-1:0]     tok_best_in,
  output logic                     tok_found,
  output logic [TIME_BITS-1:0]     tok_best,
  output crs_pkg::event_t          ev,
  output crs_pkg::mode_t           mode,
  output logic [TIME_BITS-1:0]     deadline,
  output logic                     never
);

  crs_pkg::mode_t       mode_next;
  logic [TIME_BITS-1:0] deadline_next;
  logic                 never_next;
  logic [TIME_BITS:0]   sum;
  logic [TIME_BITS-1:0] sched;
  logic                 contrib;

  assign sum   = {1'b0, now} + {1'b0, interval};
  assign sched = sum[TIME_BITS] ? '1 : sum[TIME_BITS-1:0];

  always_comb begin
    mode_next     = mode;
    deadline_next = deadline;
    never_next    = never;
    ev            = crs_pkg::EV_NONE;
    if (cmd.action == crs_pkg::ACT_MARK_DOWN) begin
      if (mode == crs_pkg::MODE_CONNECTED) begin
        mode_next = crs_pkg::MODE_DOWN;
        ev        = crs_pkg::EV_MARKED_DOWN;
      end
    end else begin
      unique case (mode)
        crs_pkg::MODE_CONNECTING: begin
          if (cmd.open_result == crs_pkg::RES_DONE) begin
            mode_next = crs_pkg::MODE_CONNECTED;
            ev        = crs_pkg::EV_CONNECTED;
          end else if (cmd.open_result != crs_pkg::RES_PENDING) begin
            mode_next = crs_pkg::MODE_DOWN;
            ev        = crs_pkg::EV_CONN_FAILED;
          end
        end
        crs_pkg::MODE_DOWN: begin
          if (!never && now >= deadline) begin
            if (cmd.start_ok) begin
              mode_next = crs_pkg::MODE_CONNECTING;
              ev        = crs_pkg::EV_STARTED;
            end else begin
              ev = crs_pkg::EV_START_FAILED;
            end
          end
        end
        default: ;
      endcase
    end
    if (ev == crs_pkg::EV_MARKED_DOWN || ev == crs_pkg::EV_CONN_FAILED ||
        ev == crs_pkg::EV_START_FAILED) begin
      if (cmd.iv_zero) begin
        never_next    = 1'b1;
        deadline_next = '0;
      end else begin
        never_next    = 1'b0;
        deadline_next = sched;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode     <= crs_pkg::MODE_DOWN;
      deadline <= '0;
      never    <= 1'b0;
    end else if (sel) begin
      mode     <= mode_next;
      deadline <= deadline_next;
      never    <= never_next;
    end
  end

  // running minimum, handed on one cell per cycle
  assign contrib = active && mode == crs_pkg::MODE_DOWN && !never;

  always_ff @(posedge clk) begin
    tok_found <= tok_found_in | contrib;
    if (contrib && (!tok_found_in || deadline < tok_best_in)) begin
      tok_best <= deadline;
    end else begin
      tok_best <= tok_best_in;
    end
  end

endmodule

`default_nettype wire
